FILE: rtl/utf8_bitmap_text_renderer_core_defines.svh
// Assertion shorthands, clocked on clock and switched off while reset is high.
`ifndef UTF8_BITMAP_TEXT_RENDERER_CORE_DEFINES_SVH
`define UTF8_BITMAP_TEXT_RENDERER_CORE_DEFINES_SVH

// Same-cycle implication.
`define UBTR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define UBTR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ubtr_pkg.sv
package ubtr_pkg;

   localparam int GLYPH_COUNT  = 4096;
   localparam int GLYPH_ROWS   = 12;
   localparam int CODE_W       = $clog2(GLYPH_COUNT);
   localparam int ROWCNT_W     = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
   localparam int ROWMEM_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
   localparam int ROWMEM_AW    = $clog2(ROWMEM_DEPTH);

   localparam logic [7:0]  ASCII_LIMIT = 8'h80;
   localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
   localparam logic [7:0]  LEAD2_TAG   = 8'hC0;
   localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
   localparam logic [7:0]  LEAD3_TAG   = 8'hE0;
   localparam logic [7:0]  LOW5_MASK   = 8'h1F;
   localparam logic [7:0]  LOW6_MASK   = 8'h3F;
   localparam logic [7:0]  LOW4_MASK   = 8'h0F;
   localparam logic [15:0] SUBST_CODE  = 16'h003F;

   localparam logic [12:0] RESET_SURFACE_WIDTH  = 13'd320;
   localparam logic [12:0] RESET_SURFACE_HEIGHT = 13'd200;
   localparam logic [12:0] RESET_ROW_PITCH      = 13'd320;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_BYTE  = 2'd1,
      ACT_ROW   = 2'd2,
      ACT_WIDTH = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CFG_SURFACE_WIDTH  = 2'd0,
      CFG_SURFACE_HEIGHT = 2'd1,
      CFG_ROW_PITCH      = 2'd2
   } cfg_index_type;

endpackage

FILE: rtl/ubtr_intf.sv
interface ubtr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  text_byte;
   logic [11:0] start_x;
   logic [11:0] start_y;
   logic [7:0]  ink_color;
   logic [11:0] load_code;
   logic [3:0]  load_row;
   logic [15:0] load_bits;
   logic [7:0]  load_width;

   modport source (output valid, action, text_byte, start_x, start_y, ink_color,
                   load_code, load_row, load_bits, load_width, input ready);
   modport sink (input valid, action, text_byte, start_x, start_y, ink_color,
                 load_code, load_row, load_bits, load_width, output ready);
endinterface

interface ubtr_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_address;
   logic [15:0] write_mask;
   logic [7:0]  write_color;
   logic        last_row;

   modport source (output valid, pixel_address, write_mask, write_color, last_row,
                   input ready);
   modport sink (input valid, pixel_address, write_mask, write_color, last_row,
                 output ready);
endinterface

interface ubtr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [12:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

FILE: rtl/utf8_bitmap_text_renderer_core.sv
// UTF-8 text renderer. Text bytes arrive on req_if and are decoded into code points
// (one, two or three byte forms); each finished code point with a nonzero loaded
// width is drawn as one masked row write per glyph row that lies on the surface,
// and the pen then advances by the glyph width. A text beat that completes a
// drawable glyph goes through a width read and a width check, then, for each row
// written (at most 12), one read of the glyph store and one emit step, in which
// the address adder steps the surface address by the row pitch. Results leave
// through an output register, so the next text beat can be taken while the last
// row write still waits. After reset the width table is cleared one entry per
// cycle, during which no request beat is taken; register writes on csr_if are
// accepted at any time.
`include "utf8_bitmap_text_renderer_core_defines.svh"

module utf8_bitmap_text_renderer_core (
   input  logic           clock,
   input  logic           reset,
   ubtr_req_if.sink       req_if,
   ubtr_rsp_if.source     rsp_if,
   ubtr_csr_if.sink       csr_if
);

   localparam int GlyphCount = ubtr_pkg::GLYPH_COUNT;
   localparam int GlyphRows  = ubtr_pkg::GLYPH_ROWS;
   localparam int CodeW      = ubtr_pkg::CODE_W;
   localparam int RowCntW    = ubtr_pkg::ROWCNT_W;
   localparam int RowMemAw   = ubtr_pkg::ROWMEM_AW;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_WREAD = 6'b000100,
      S_WCHK  = 6'b001000,
      S_RREAD = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [12:0] surf_w_ff, surf_h_ff, pitch_ff;
   logic [15:0] pen_x_ff, pen_x_in;
   logic [11:0] pen_y_ff, pen_y_in;
   logic [7:0]  color_ff, color_in;
   logic [1:0]  pend_ff, pend_in;
   logic [15:0] partial_ff, partial_in;
   logic [15:0] code_ff, code_in;
   logic [RowCntW-1:0]  row_ff, row_in;
   logic [23:0] addr_ff, addr_in;
   logic [RowMemAw-1:0] gaddr_ff, gaddr_in;
   logic [CodeW-1:0]    clr_ff, clr_in;

   logic [7:0]  width_mem [GlyphCount];
   logic [15:0] row_mem [ubtr_pkg::ROWMEM_DEPTH];
   logic [7:0]  width_rd_ff;
   logic [15:0] bits_rd_ff;

   logic        rsp_valid_ff;
   logic [23:0] rsp_addr_ff;
   logic [15:0] rsp_mask_ff;
   logic [7:0]  rsp_color_ff;
   logic        rsp_last_ff;

   logic              accept;
   logic [7:0]        b;
   logic              dec_draw;
   logic [15:0]       dec_cp;
   logic [1:0]        dec_pend;
   logic [15:0]       dec_partial;
   logic [CodeW-1:0]  code_idx;
   logic              in_store;
   logic [12:0]       ysum, ynext;
   logic              last;
   logic [16:0]       pen_adv;
   logic [15:0]       pen_x_sat;
   logic [24:0]       prod;
   logic [23:0]       base_addr;
   logic              emit_go;
   logic [15:0]       mask;
   logic [16:0]       col;
   logic              wm_we;
   logic [CodeW-1:0]  wm_addr;
   logic [7:0]        wm_data;
   logic              rm_we;
   logic [RowMemAw-1:0] rm_addr;

   assign accept    = req_if.valid && req_if.ready;
   assign b         = req_if.text_byte;
   assign code_idx  = code_ff[CodeW-1:0];
   assign in_store  = {1'b0, code_ff} < 17'(GlyphCount);
   assign ysum      = 13'(pen_y_ff) + 13'(row_ff);
   assign ynext     = ysum + 13'd1;
   assign last      = (row_ff == RowCntW'(GlyphRows - 1)) || (ynext >= surf_h_ff);
   assign pen_adv   = 17'(pen_x_ff) + 17'(width_rd_ff);
   assign pen_x_sat = pen_adv[16] ? 16'hFFFF : pen_adv[15:0];
   assign prod      = 25'(pen_y_ff) * 25'(pitch_ff);
   assign base_addr = prod[23:0] + 24'(pen_x_ff);
   assign emit_go   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_if.ready);

   // UTF-8 decode of the incoming text byte
   always_comb begin
      dec_draw    = 1'b0;
      dec_cp      = '0;
      dec_pend    = 2'd0;
      dec_partial = '0;
      if (pend_ff == 2'd2) begin
         dec_partial = partial_ff | (16'(b & ubtr_pkg::LOW6_MASK) << 6);
         dec_pend    = 2'd1;
      end else if (pend_ff == 2'd1) begin
         dec_cp   = partial_ff | 16'(b & ubtr_pkg::LOW6_MASK);
         dec_draw = 1'b1;
      end else if (b < ubtr_pkg::ASCII_LIMIT) begin
         dec_cp   = 16'(b);
         dec_draw = 1'b1;
      end else if ((b & ubtr_pkg::LEAD2_MASK) == ubtr_pkg::LEAD2_TAG) begin
         dec_partial = 16'(b & ubtr_pkg::LOW5_MASK) << 6;
         dec_pend    = 2'd1;
      end else if ((b & ubtr_pkg::LEAD3_MASK) == ubtr_pkg::LEAD3_TAG) begin
         dec_partial = 16'(b & ubtr_pkg::LOW4_MASK) << 12;
         dec_pend    = 2'd2;
      end else begin
         dec_cp   = ubtr_pkg::SUBST_CODE;
         dec_draw = 1'b1;
      end
   end

   // Clip columns at the surface width; bit 15 of the glyph row is leftmost
   always_comb begin
      mask = '0;
      col  = '0;
      for (int k = 0; k < 16; k++) begin
         col     = 17'(pen_x_ff) + 17'(k);
         mask[k] = (col < 17'(surf_w_ff)) && bits_rd_ff[15 - k];
      end
   end

   always_comb begin
      state_in   = state_ff;
      pen_x_in   = pen_x_ff;
      pen_y_in   = pen_y_ff;
      color_in   = color_ff;
      pend_in    = pend_ff;
      partial_in = partial_ff;
      code_in    = code_ff;
      row_in     = row_ff;
      addr_in    = addr_ff;
      gaddr_in   = gaddr_ff;
      clr_in     = clr_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + CodeW'(1);
            if (clr_ff == CodeW'(GlyphCount - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_if.action)
                  ubtr_pkg::ACT_START: begin
                     pen_x_in   = 16'(req_if.start_x);
                     pen_y_in   = req_if.start_y;
                     color_in   = req_if.ink_color;
                     pend_in    = 2'd0;
                     partial_in = '0;
                  end
                  ubtr_pkg::ACT_BYTE: begin
                     pend_in    = dec_pend;
                     partial_in = dec_partial;
                     if (dec_draw) begin
                        code_in  = dec_cp;
                        state_in = S_WREAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WREAD: begin
            addr_in  = base_addr;
            gaddr_in = RowMemAw'(code_idx) * RowMemAw'(GlyphRows);
            row_in   = '0;
            state_in = S_WCHK;
         end
         S_WCHK: begin
            if (!in_store || width_rd_ff == 8'd0) begin
               state_in = S_IDLE;
            end else if (13'(pen_y_ff) >= surf_h_ff) begin
               // nothing on the surface, but the pen still moves
               pen_x_in = pen_x_sat;
               state_in = S_IDLE;
            end else begin
               state_in = S_RREAD;
            end
         end
         S_RREAD: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (emit_go) begin
               if (last) begin
                  pen_x_in = pen_x_sat;
                  state_in = S_IDLE;
               end else begin
                  row_in   = row_ff + RowCntW'(1);
                  gaddr_in = gaddr_ff + RowMemAw'(1);
                  addr_in  = addr_ff + 24'(pitch_ff);
                  state_in = S_RREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         pen_x_ff   <= '0;
         pen_y_ff   <= '0;
         color_ff   <= '0;
         pend_ff    <= '0;
         partial_ff <= '0;
         code_ff    <= '0;
         row_ff     <= '0;
         clr_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         pen_x_ff   <= pen_x_in;
         pen_y_ff   <= pen_y_in;
         color_ff   <= color_in;
         pend_ff    <= pend_in;
         partial_ff <= partial_in;
         code_ff    <= code_in;
         row_ff     <= row_in;
         clr_ff     <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      gaddr_ff <= gaddr_in;
   end

   // Configuration registers
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         surf_w_ff <= ubtr_pkg::RESET_SURFACE_WIDTH;
         surf_h_ff <= ubtr_pkg::RESET_SURFACE_HEIGHT;
         pitch_ff  <= ubtr_pkg::RESET_ROW_PITCH;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            ubtr_pkg::CFG_SURFACE_WIDTH:  surf_w_ff <= csr_if.wdata;
            ubtr_pkg::CFG_SURFACE_HEIGHT: surf_h_ff <= csr_if.wdata;
            ubtr_pkg::CFG_ROW_PITCH:      pitch_ff  <= csr_if.wdata;
            default: begin
            end
         endcase
      end
   end

   // Width table: cleared after reset, then loaded by width beats
   always_comb begin
      wm_we   = 1'b0;
      wm_addr = clr_ff;
      wm_data = 8'd0;
      if (state_ff == S_CLEAR) begin
         wm_we = 1'b1;
      end else if (accept && req_if.action == ubtr_pkg::ACT_WIDTH
                   && 17'(req_if.load_code) < 17'(GlyphCount)) begin
         wm_we   = 1'b1;
         wm_addr = CodeW'(req_if.load_code);
         wm_data = req_if.load_width;
      end
   end

   always_ff @(posedge clock) begin
      if (wm_we) begin
         width_mem[wm_addr] <= wm_data;
      end
      width_rd_ff <= width_mem[code_idx];
   end

   // Glyph row store
   assign rm_we = accept && req_if.action == ubtr_pkg::ACT_ROW
                  && 17'(req_if.load_code) < 17'(GlyphCount)
                  && 5'(req_if.load_row) < 5'(GlyphRows);
   assign rm_addr = RowMemAw'(CodeW'(req_if.load_code)) * RowMemAw'(GlyphRows)
                    + RowMemAw'(req_if.load_row);

   always_ff @(posedge clock) begin
      if (rm_we) begin
         row_mem[rm_addr] <= req_if.load_bits;
      end
      bits_rd_ff <= row_mem[gaddr_ff];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_addr_ff  <= addr_ff;
         rsp_mask_ff  <= mask;
         rsp_color_ff <= color_ff;
         rsp_last_ff  <= last;
      end
   end

   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.pixel_address = rsp_addr_ff;
   assign rsp_if.write_mask    = rsp_mask_ff;
   assign rsp_if.write_color   = rsp_color_ff;
   assign rsp_if.last_row      = rsp_last_ff;

   `UBTR_ASSERT_NOW(a_wchk_after_wread, state_ff == S_WCHK, $past(state_ff) == S_WREAD,
      "width check entered without a width read")
   `UBTR_ASSERT_NOW(a_row_in_range, state_ff == S_EMIT, row_ff <= RowCntW'(GlyphRows - 1),
      "row counter beyond glyph height")
   `UBTR_ASSERT_NEXT(a_last_ends_glyph, emit_go && last, state_ff == S_IDLE,
      "final row write did not end the glyph")
   `UBTR_ASSERT_NEXT(a_pen_no_retreat, emit_go && last, pen_x_ff >= $past(pen_x_ff),
      "pen moved backwards after a glyph")

endmodule

FILE: verif/utf8_bitmap_text_renderer_core_tb.sv
`timescale 1ns / 1ps

module utf8_bitmap_text_renderer_core_tb;

   localparam int SETTLE_CYCLES  = 40;
   localparam int STALL_LIMIT    = 20000;
   localparam int HOLD_CYCLES    = 200;
   localparam int PHASE_BEATS    = 5;
   localparam int PHASE_COUNT    = 4;
   localparam int SAT_GLYPHS     = 244;
   localparam int NO_TYPED_COUNT = -1;

   typedef struct {
      ubtr_pkg::action_type action;
      logic [7:0]  text_byte;
      logic [11:0] start_x;
      logic [11:0] start_y;
      logic [7:0]  ink_color;
      logic [11:0] load_code;
      logic [3:0]  load_row;
      logic [15:0] load_bits;
      logic [7:0]  load_width;
   } req_beat_type;

   typedef struct packed {
      logic [23:0] pixel_address;
      logic [15:0] write_mask;
      logic [7:0]  write_color;
      logic        last_row;
   } row_write_type;

   typedef struct {
      req_beat_type beat;
      int           rows;
   } plan_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ubtr_req_if req_if ();
   ubtr_rsp_if rsp_if ();
   ubtr_csr_if csr_if ();

   utf8_bitmap_text_renderer_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // renderer state as the predictor sees it
   logic [15:0] font_rows [ubtr_pkg::ROWMEM_DEPTH];
   bit   [7:0]  glyph_advance [ubtr_pkg::GLYPH_COUNT];
   logic [15:0] pen_x = '0;
   logic [11:0] pen_y = '0;
   logic [7:0]  ink = '0;
   logic [1:0]  seq_left = '0;
   logic [15:0] partial = '0;
   logic [12:0] surf_w = ubtr_pkg::RESET_SURFACE_WIDTH;
   logic [12:0] surf_h = ubtr_pkg::RESET_SURFACE_HEIGHT;
   logic [12:0] pitch = ubtr_pkg::RESET_ROW_PITCH;

   row_write_type pending_row_writes [$];
   int            drawable_codes [$];
   bit            listed [ubtr_pkg::GLYPH_COUNT];
   plan_step_type plan [$];

   bit req_gaps_on = 1'b1;
   bit rsp_gaps_on = 1'b1;
   bit rsp_hold = 1'b0;
   int fails = 0;
   int beats_sent = 0;
   int rows_checked = 0;
   int settings_used = 0;

   function automatic int draw_glyph(input logic [15:0] cp);
      int w;
      int nrows;
      int y;
      int sum;
      logic [15:0] bits;
      row_write_type rw;
      if (cp >= ubtr_pkg::GLYPH_COUNT) return 0;
      w = glyph_advance[cp];
      if (w == 0) return 0;
      nrows = int'(surf_h) - int'(pen_y);
      if (nrows < 0) nrows = 0;
      if (nrows > ubtr_pkg::GLYPH_ROWS) nrows = ubtr_pkg::GLYPH_ROWS;
      for (int i = 0; i < nrows; i++) begin
         y = int'(pen_y) + i;
         bits = font_rows[int'(cp) * ubtr_pkg::GLYPH_ROWS + i];
         rw.write_mask = '0;
         for (int k = 0; k < 16; k++)
            if (int'(pen_x) + k < int'(surf_w) && bits[15 - k]) rw.write_mask[k] = 1'b1;
         rw.pixel_address = 24'(y * int'(pitch) + int'(pen_x));
         rw.write_color = ink;
         rw.last_row = (i == nrows - 1);
         pending_row_writes.push_back(rw);
      end
      // advance saturates at 16 bits
      sum = int'(pen_x) + w;
      pen_x = (sum > 16'hFFFF) ? 16'hFFFF : 16'(sum);
      return nrows;
   endfunction

   function automatic int advance_renderer(input req_beat_type b);
      logic [15:0] cp;
      case (b.action)
         ubtr_pkg::ACT_START: begin
            pen_x = {4'b0, b.start_x};
            pen_y = b.start_y;
            ink = b.ink_color;
            seq_left = '0;
            partial = '0;
            return 0;
         end
         ubtr_pkg::ACT_ROW: begin
            if (b.load_code < ubtr_pkg::GLYPH_COUNT && b.load_row < ubtr_pkg::GLYPH_ROWS)
               font_rows[int'(b.load_code) * ubtr_pkg::GLYPH_ROWS + int'(b.load_row)] =
                  b.load_bits;
            return 0;
         end
         ubtr_pkg::ACT_WIDTH: begin
            if (b.load_code < ubtr_pkg::GLYPH_COUNT) glyph_advance[b.load_code] = b.load_width;
            return 0;
         end
         default: begin
            // any byte counts as a continuation while a sequence is open
            if (seq_left == 2) begin
               partial = partial | (16'(b.text_byte & ubtr_pkg::LOW6_MASK) << 6);
               seq_left = 1;
               return 0;
            end
            if (seq_left == 1) begin
               cp = partial | 16'(b.text_byte & ubtr_pkg::LOW6_MASK);
               seq_left = 0;
               partial = '0;
               return draw_glyph(cp);
            end
            if (b.text_byte < ubtr_pkg::ASCII_LIMIT) return draw_glyph({8'b0, b.text_byte});
            if ((b.text_byte & ubtr_pkg::LEAD2_MASK) == ubtr_pkg::LEAD2_TAG) begin
               partial = 16'(b.text_byte & ubtr_pkg::LOW5_MASK) << 6;
               seq_left = 1;
               return 0;
            end
            if ((b.text_byte & ubtr_pkg::LEAD3_MASK) == ubtr_pkg::LEAD3_TAG) begin
               partial = 16'(b.text_byte & ubtr_pkg::LOW4_MASK) << 12;
               seq_left = 2;
               return 0;
            end
            return draw_glyph(ubtr_pkg::SUBST_CODE);
         end
      endcase
   endfunction

   function automatic req_beat_type random_beat();
      req_beat_type b;
      b.action = ubtr_pkg::action_type'($urandom_range(0, 3));
      b.text_byte = 8'($urandom);
      b.start_x = 12'($urandom);
      b.start_y = 12'($urandom);
      b.ink_color = 8'($urandom);
      b.load_code = 12'($urandom);
      b.load_row = 4'($urandom);
      b.load_bits = 16'($urandom);
      b.load_width = 8'($urandom);
      return b;
   endfunction

   function automatic req_beat_type text_beat(input logic [7:0] ch);
      req_beat_type b;
      b = random_beat();
      b.action = ubtr_pkg::ACT_BYTE;
      b.text_byte = ch;
      return b;
   endfunction

   function automatic req_beat_type start_beat(input int x, input int y, input int colour);
      req_beat_type b;
      b = random_beat();
      b.action = ubtr_pkg::ACT_START;
      b.start_x = 12'(x);
      b.start_y = 12'(y);
      b.ink_color = 8'(colour);
      return b;
   endfunction

   function automatic req_beat_type row_beat(input int code, input int row, input int bits);
      req_beat_type b;
      b = random_beat();
      b.action = ubtr_pkg::ACT_ROW;
      b.load_code = 12'(code);
      b.load_row = 4'(row);
      b.load_bits = 16'(bits);
      return b;
   endfunction

   function automatic req_beat_type width_beat(input int code, input int w);
      req_beat_type b;
      b = random_beat();
      b.action = ubtr_pkg::ACT_WIDTH;
      b.load_code = 12'(code);
      b.load_width = 8'(w);
      return b;
   endfunction

   function automatic void plan_step(input req_beat_type b, input int rows);
      plan_step_type s;
      s.beat = b;
      s.rows = rows;
      plan.push_back(s);
   endfunction

   task automatic push_req(input req_beat_type b, output int rows);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.action <= b.action;
      req_if.text_byte <= b.text_byte;
      req_if.start_x <= b.start_x;
      req_if.start_y <= b.start_y;
      req_if.ink_color <= b.ink_color;
      req_if.load_code <= b.load_code;
      req_if.load_row <= b.load_row;
      req_if.load_bits <= b.load_bits;
      req_if.load_width <= b.load_width;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      rows = advance_renderer(b);
      beats_sent++;
   endtask

   // width goes in last, so a drawable glyph never has an unwritten row
   task automatic install_glyph(input int code, input int w);
      int n;
      int off;
      off = $urandom_range(0, ubtr_pkg::GLYPH_ROWS - 1);
      for (int i = 0; i < ubtr_pkg::GLYPH_ROWS; i++)
         push_req(row_beat(code, (i + off) % ubtr_pkg::GLYPH_ROWS, $urandom), n);
      push_req(width_beat(code, w), n);
      if (!listed[code]) begin
         listed[code] = 1'b1;
         drawable_codes.push_back(code);
      end
   endtask

   task automatic send_code(input logic [15:0] cp);
      int n;
      if (cp < 16'h0080 && $urandom_range(0, 2) != 0) begin
         push_req(text_beat(cp[7:0]), n);
      end else if (cp < 16'h0800 && $urandom_range(0, 3) != 0) begin
         push_req(text_beat(ubtr_pkg::LEAD2_TAG | {3'b0, cp[10:6]}), n);
         push_req(text_beat({2'($urandom), cp[5:0]}), n);
      end else begin
         // three-byte form, overlong for small codes
         push_req(text_beat(ubtr_pkg::LEAD3_TAG | {4'b0, cp[15:12]}), n);
         push_req(text_beat({2'($urandom), cp[11:6]}), n);
         push_req(text_beat({2'($urandom), cp[5:0]}), n);
      end
   endtask

   task automatic write_surface(input int w, input int h, input int p);
      logic [12:0] vals [3];
      vals[0] = 13'(w);
      vals[1] = 13'(h);
      vals[2] = 13'(p);
      for (int i = 0; i < 3; i++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= ubtr_pkg::cfg_index_type'(i);
         csr_if.wdata <= vals[i];
         do @(posedge clock); while (csr_if.ready !== 1'b1);
         case (ubtr_pkg::cfg_index_type'(i))
            ubtr_pkg::CFG_SURFACE_WIDTH:  surf_w = vals[i];
            ubtr_pkg::CFG_SURFACE_HEIGHT: surf_h = vals[i];
            default:                      pitch = vals[i];
         endcase
      end
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic drain_and_wait();
      req_if.valid <= 1'b0;
      while (pending_row_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_step();
      int n;
      int r;
      int lim_x;
      int lim_y;
      r = $urandom_range(0, 99);
      lim_x = (int'(surf_w) + 8 > 4095) ? 4095 : int'(surf_w) + 8;
      lim_y = (int'(surf_h) > 4095) ? 4095 : int'(surf_h);
      if (r < 45) begin
         send_code(16'(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)]));
      end else if (r < 55) begin
         if ($urandom_range(0, 3) != 0)
            push_req(start_beat($urandom_range(0, lim_x), $urandom_range(0, lim_y),
                                $urandom), n);
         else
            push_req(start_beat($urandom_range(0, 4095), $urandom_range(0, 4095),
                                $urandom), n);
      end else if (r < 65) begin
         push_req(text_beat(8'($urandom)), n);
      end else if (r < 73) begin
         push_req(row_beat($urandom_range(0, 4095), $urandom_range(0, 15), $urandom), n);
      end else if (r < 80) begin
         if ($urandom_range(0, 2) != 0)
            push_req(width_beat(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)],
                                $urandom_range(0, 255)), n);
         else
            push_req(width_beat($urandom_range(0, 4095), 0), n);
      end else if (r < 84) begin
         install_glyph($urandom_range(0, 4095), $urandom_range(1, 255));
      end else if (r < 90) begin
         // open a sequence, then break it with a start beat or feed it a random byte
         push_req(text_beat(8'($urandom_range(8'hC0, 8'hEF))), n);
         if ($urandom_range(0, 1) != 0)
            push_req(start_beat($urandom_range(0, lim_x), $urandom_range(0, lim_y),
                                $urandom), n);
         else
            push_req(text_beat(8'($urandom)), n);
      end else begin
         send_code(16'($urandom));
      end
   endtask

   // result side
   initial begin : rsp_side
      int gap;
      row_write_type got;
      row_write_type want;
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (rsp_hold) begin
            gap = HOLD_CYCLES;
            rsp_hold = 1'b0;
         end else begin
            gap = rsp_gaps_on ? $urandom_range(0, 4) : 0;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         got = {rsp_if.pixel_address, rsp_if.write_mask, rsp_if.write_color, rsp_if.last_row};
         if (pending_row_writes.size() == 0) begin
            $error("row write with nothing expected: address %h mask %h",
                   got.pixel_address, got.write_mask);
            fails++;
         end else begin
            want = pending_row_writes.pop_front();
            rows_checked++;
            if (got.pixel_address !== want.pixel_address) begin
               $error("pixel_address: expected %h, got %h", want.pixel_address,
                      got.pixel_address);
               fails++;
            end
            if (got.write_mask !== want.write_mask) begin
               $error("write_mask: expected %h, got %h", want.write_mask, got.write_mask);
               fails++;
            end
            if (got.write_color !== want.write_color) begin
               $error("write_color: expected %h, got %h", want.write_color,
                      got.write_color);
               fails++;
            end
            if (got.last_row !== want.last_row) begin
               $error("last_row: expected %b, got %b", want.last_row, got.last_row);
               fails++;
            end
         end
      end
   end

   // end the run if no beat moves on any channel for too long
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (csr_if.valid === 1'b1 && csr_if.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : req_side
      int rows;
      int quota;
      int w;
      int h;
      int p;
      req_if.valid <= 1'b0;
      req_if.action <= ubtr_pkg::ACT_START;
      req_if.text_byte <= '0;
      req_if.start_x <= '0;
      req_if.start_y <= '0;
      req_if.ink_color <= '0;
      req_if.load_code <= '0;
      req_if.load_row <= '0;
      req_if.load_bits <= '0;
      req_if.load_width <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= ubtr_pkg::CFG_SURFACE_WIDTH;
      csr_if.wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      install_glyph(12'h000, 8);
      install_glyph(12'h03F, 6);
      install_glyph(12'h041, 8);
      install_glyph(12'h042, 0);
      install_glyph(12'h7FF, 10);
      install_glyph(12'hFFF, 255);

      plan_step(text_beat(8'h41), 12);                 // reset pen and surface
      plan_step(start_beat(0, 0, 8'hFF), 0);
      plan_step(text_beat(8'h00), 12);                 // zero byte is code 0
      plan_step(text_beat(8'h42), 0);                  // width zero
      plan_step(text_beat(8'hFF), 12);                 // bad lead gives '?'
      plan_step(text_beat(8'h80), 12);                 // stray continuation as lead
      plan_step(text_beat(8'hF5), 12);
      plan_step(text_beat(8'hDF), 0);
      plan_step(text_beat(8'hBF), 12);                 // top two-byte code
      plan_step(text_beat(8'hE0), 0);
      plan_step(text_beat(8'h3F), 0);                  // continuation tag not checked
      plan_step(text_beat(8'hFF), 12);
      plan_step(text_beat(8'hEF), 0);
      plan_step(text_beat(8'hBF), 0);
      plan_step(text_beat(8'hBF), 0);                  // beyond the store
      plan_step(text_beat(8'hC3), 0);
      plan_step(start_beat(316, 195, 8'h5A), 0);       // drops the open sequence
      plan_step(text_beat(8'h41), 5);                  // bottom rows and right columns clip
      plan_step(row_beat(12'h041, 12, $urandom), 0);   // row out of range
      plan_step(row_beat(12'hFFF, 15, $urandom), 0);
      plan_step(text_beat(8'h41), NO_TYPED_COUNT);     // mask fully clipped
      plan_step(width_beat(12'h042, 9), 0);
      plan_step(start_beat(4095, 4095, 8'h00), 0);
      plan_step(text_beat(8'h3F), 0);                  // all rows below surface
      plan_step(start_beat(8, 20, 8'h33), 0);
      plan_step(text_beat(8'h42), NO_TYPED_COUNT);
      plan_step(width_beat(12'h041, 0), 0);
      plan_step(text_beat(8'h41), 0);
      plan_step(text_beat(8'h00), 12);

      foreach (plan[i]) begin
         push_req(plan[i].beat, rows);
         if (plan[i].rows != NO_TYPED_COUNT && rows != plan[i].rows) begin
            $error("row write count of step %0d: expected %0d, got %0d", i,
                   plan[i].rows, rows);
            fails++;
         end
      end
      drain_and_wait();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         if (ph == 0) begin
            w = 4096; h = 4096; p = 4096;
         end else if (ph == 1) begin
            w = 1; h = 1; p = 1;
         end else begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 400);
            h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 400);
            p = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 400);
         end
         write_surface(w, h, p);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         if (ph == 0) begin
            install_glyph(12'h07E, 255);
            // bottom row only: hold the result side while glyphs keep arriving,
            // then the pen runs into saturation and the address wraps
            push_req(start_beat(4095, 4095, $urandom), rows);
            rsp_hold = 1'b1;
            repeat (SAT_GLYPHS) push_req(text_beat(8'h7E), rows);
         end
         quota = beats_sent + PHASE_BEATS;
         while (beats_sent < quota) random_step();
         drain_and_wait();
      end

      $display("Covered %0d request beats and %0d row writes over %0d surface settings,",
               beats_sent, rows_checked, settings_used);
      $display("with clipping, pen saturation, address wrap and a long result stall.");
      if (fails == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
